/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the integrator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Plain property, sampled on the rising clock, off while reset is active.
`define RK_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Overlapping implication, sampled on the rising clock, off while reset is active.
`define RK_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);
`else
`define RK_ASSERT(name, clk, rstn, prop, msg)
`define RK_ASSERT_IMPL(name, clk, rstn, ante, cons, msg)
`endif

`endif

/* rtl/core/rk4dc_pkg.sv */
// ----------------------------------------------------------------------------
// rk4dc_pkg
// Constants and shared types of the damped cell integrator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rk4dc_pkg;

  // Width of the time step register (unsigned Q0.16).
  localparam int unsigned DT_BITS = 16;
  // Width of dt/6 held as a Q0.32 fraction.
  localparam int unsigned DT6_W = 30;
  // Reciprocal of three for an exact floor(x/3) on 32-bit x (shift by 33).
  localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;
  localparam logic [DT_BITS-1:0] TS_RESET = 16'd655;
  localparam logic [DT6_W-1:0] DT6_RESET = DT6_W'((64'(TS_RESET) << DT_BITS) / 6);

  // Control that travels with every pipeline stage.
  typedef struct packed {
    logic valid;
    logic ovf;
  } stage_flags_t;

endpackage

/* rtl/core/rk4dc_if.sv */
// ----------------------------------------------------------------------------
// rk4dc_if
// Valid/ready channels of the integrator: cell input, result and time step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rk4dc_in_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] potential_in;
  logic signed [VALUE_WIDTH-1:0] velocity_x_in;
  logic signed [VALUE_WIDTH-1:0] velocity_y_in;
  logic        [VALUE_WIDTH-2:0] cell_mass;
  logic        [VALUE_WIDTH-2:0] cell_friction;

  modport source (output valid, potential_in, velocity_x_in, velocity_y_in, cell_mass,
                  cell_friction, input ready);
  modport sink (input valid, potential_in, velocity_x_in, velocity_y_in, cell_mass,
                cell_friction, output ready);
endinterface

interface rk4dc_out_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] potential_out;
  logic signed [VALUE_WIDTH-1:0] velocity_x_out;
  logic signed [VALUE_WIDTH-1:0] velocity_y_out;
  logic                          overflow_flag;

  modport source (output valid, potential_out, velocity_x_out, velocity_y_out,
                  overflow_flag, input ready);
  modport sink (input valid, potential_out, velocity_x_out, velocity_y_out,
                overflow_flag, output ready);
endinterface

interface rk4dc_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] time_step;

  modport source (output valid, time_step, input ready);
  modport sink (input valid, time_step, output ready);
endinterface

/* rtl/core/rk4_damped_cell_integrator.sv */
// ----------------------------------------------------------------------------
// rk4_damped_cell_integrator
// One classical fourth-order Runge-Kutta step of a damped grid cell.
// ----------------------------------------------------------------------------
// Usage: each transaction on data_in_i carries one cell (potential, both
// velocities, mass and friction, all fixed point). Each accepted cell gives
// exactly one transaction on result_o with the updated potential and
// velocities and an overflow flag that is set when any saturation occurred.
// The step size dt is held in a register written over cfg_i; cfg_i is always
// ready and should only be written while no cell is in flight.
// The four derivative evaluations dominate the path from input acceptance to
// a valid result: each holds a restoring divider for p/m that retires one
// quotient bit per stage. Throughput is one cell per clock cycle while the
// skid register is empty; cells are independent.
// Reset clears all valid bits and loads dt with its default of 655; no
// clearing pass is needed, the block is ready right after reset.
// When the receiver stalls, the result waits in the output register and one
// more result lands in a skid register; only then does data_in_i.ready drop
// and the whole pipeline hold, losing and repeating nothing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rk4_damped_cell_integrator #(
  parameter int unsigned FRACTION_BITS = 16,
  parameter int unsigned VALUE_WIDTH   = 32
) (
  input logic         clk_i,
  input logic         rst_ni,
  rk4dc_cfg_if.sink   cfg_i,
  rk4dc_in_if.sink    data_in_i,
  rk4dc_out_if.source result_o
);
  import rk4dc_pkg::*;

  localparam int unsigned W    = VALUE_WIDTH;
  localparam int unsigned KW   = W + 3;
  localparam int unsigned PW   = W + DT_BITS + 1;
  localparam int unsigned WIDE = W + 40;
  localparam int unsigned LW   = KW + DT_BITS + 1;
  localparam int unsigned HW   = KW + DT6_W - DT_BITS + 1;
  localparam logic signed [WIDE-1:0] VMAX_X = {{(WIDE - W + 1){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [WIDE-1:0] VMIN_X = {{(WIDE - W + 1){1'b1}}, {(W - 1){1'b0}}};

  // Context that rides along the derivative pipelines: the original state and
  // the running weighted sum k1 + 2*k2 + 2*k3 (+ k4).
  typedef struct packed {
    logic [2:0][W-1:0]  y;
    logic [2:0][KW-1:0] s;
  } ctx_t;
  localparam int unsigned CTX_W = $bits(ctx_t);

  typedef struct packed {
    logic [W-1:0] pot;
    logic [W-1:0] vx;
    logic [W-1:0] vy;
    logic         ovf;
  } res_t;

  function automatic logic [W:0] sat_w(input logic signed [WIDE-1:0] x);
    logic [W:0] r;
    if (x > VMAX_X) begin
      r = {1'b1, 1'b0, {(W - 1){1'b1}}};
    end else if (x < VMIN_X) begin
      r = {1'b1, 1'b1, {(W - 1){1'b0}}};
    end else begin
      r = {1'b0, x[W-1:0]};
    end
    return r;
  endfunction

  // Global enable: the pipeline moves unless the skid register is occupied.
  logic en;
  logic skid_v_q;
  logic out_v_q;

  assign en              = !skid_v_q;
  assign data_in_i.ready = en;

  // Time step register and dt/6 in Q0.32, formed as floor(dt*2^15/3).
  logic [DT_BITS-1:0] time_step_q;
  logic [DT6_W-1:0]   dt6_q;
  logic [DT_BITS+14:0] dt6_x;
  logic [62:0]        dt6_prod;

  assign cfg_i.ready = 1'b1;
  assign dt6_x       = {time_step_q, {(DT_BITS - 1){1'b0}}};
  assign dt6_prod    = 63'(dt6_x) * 63'(RECIP3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= TS_RESET;
      dt6_q       <= DT6_RESET;
    end else begin
      if (cfg_i.valid) begin
        time_step_q <= cfg_i.time_step;
      end
      dt6_q <= dt6_prod[62:33];
    end
  end

  // Connections of the four derivative evaluations.
  stage_flags_t        ev_fi [4];
  stage_flags_t        ev_fo [4];
  logic signed [W-1:0] ev_p_i [4];
  logic signed [W-1:0] ev_x_i [4];
  logic signed [W-1:0] ev_y_i [4];
  logic signed [W-1:0] ev_dp [4];
  logic signed [W-1:0] ev_dx [4];
  logic signed [W-1:0] ev_dy [4];
  logic [W-2:0]        ev_m_i [4];
  logic [W-2:0]        ev_c_i [4];
  logic [W-2:0]        ev_m_o [4];
  logic [W-2:0]        ev_c_o [4];
  ctx_t                ev_ctx_i [4];
  ctx_t                ev_ctx_o [4];

  // Input register: the cell itself is the first evaluation point.
  logic         in_v_q;
  logic [W-1:0] in_p_q, in_x_q, in_y_q;
  logic [W-2:0] in_m_q, in_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (en) begin
      in_v_q <= data_in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_p_q <= data_in_i.potential_in;
      in_x_q <= data_in_i.velocity_x_in;
      in_y_q <= data_in_i.velocity_y_in;
      in_m_q <= data_in_i.cell_mass;
      in_c_q <= data_in_i.cell_friction;
    end
  end

  assign ev_fi[0]    = {in_v_q, 1'b0};
  assign ev_p_i[0]   = $signed(in_p_q);
  assign ev_x_i[0]   = $signed(in_x_q);
  assign ev_y_i[0]   = $signed(in_y_q);
  assign ev_m_i[0]   = in_m_q;
  assign ev_c_i[0]   = in_c_q;
  assign ev_ctx_i[0] = '{y: {in_y_q, in_x_q, in_p_q}, s: '0};

  for (genvar e = 0; e < 4; e++) begin : g_eval
    rk4dc_deriv #(
      .FRACTION_BITS (FRACTION_BITS),
      .VALUE_WIDTH   (VALUE_WIDTH),
      .CTX_W         (CTX_W)
    ) u_deriv (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .flags_i (ev_fi[e]),
      .pot_i   (ev_p_i[e]),
      .vx_i    (ev_x_i[e]),
      .vy_i    (ev_y_i[e]),
      .mass_i  (ev_m_i[e]),
      .fric_i  (ev_c_i[e]),
      .ctx_i   (ev_ctx_i[e]),
      .flags_o (ev_fo[e]),
      .dpot_o  (ev_dp[e]),
      .dvx_o   (ev_dx[e]),
      .dvy_o   (ev_dy[e]),
      .mass_o  (ev_m_o[e]),
      .fric_o  (ev_c_o[e]),
      .ctx_o   (ev_ctx_o[e])
    );
  end

  // Between evaluations: accumulate k with its weight, then form the next
  // evaluation point y + k*dt/2 (first two) or y + k*dt (last one).
  for (genvar e = 0; e < 3; e++) begin : g_adv
    localparam int unsigned WSH = (e == 0) ? 0 : 1;
    localparam int unsigned SH  = (e == 2) ? DT_BITS : DT_BITS + 1;

    logic signed [W-1:0]  k_w [3];
    ctx_t                 ca_d, ca_q;
    logic signed [PW-1:0] pa_d [3];
    logic signed [PW-1:0] pa_q [3];
    logic                 va_q, oa_q;
    logic [W-2:0]         ma_q, fa_q;
    logic [W-1:0]         t_d [3];
    logic [2:0]           tf_d;
    logic                 vb_q, ob_q;
    logic [W-1:0]         tb_q [3];
    logic [W-2:0]         mb_q, fb_q;
    ctx_t                 cb_q;

    assign k_w[0] = ev_dp[e];
    assign k_w[1] = ev_dx[e];
    assign k_w[2] = ev_dy[e];

    always_comb begin
      ca_d = ev_ctx_o[e];
      for (int i = 0; i < 3; i++) begin
        ca_d.s[i] = $signed(ev_ctx_o[e].s[i]) + (KW'(k_w[i]) <<< WSH);
        pa_d[i]   = k_w[i] * $signed({1'b0, time_step_q});
      end
    end

    always_comb begin
      logic [W:0] m1;
      logic [W:0] t1;
      for (int i = 0; i < 3; i++) begin
        m1 = sat_w(WIDE'(pa_q[i] >>> SH));
        t1 = sat_w(WIDE'($signed(ca_q.y[i])) + WIDE'($signed(m1[W-1:0])));
        t_d[i]  = t1[W-1:0];
        tf_d[i] = m1[W] | t1[W];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        va_q <= 1'b0;
        vb_q <= 1'b0;
      end else if (en) begin
        va_q <= ev_fo[e].valid;
        vb_q <= va_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        ca_q <= ca_d;
        pa_q <= pa_d;
        oa_q <= ev_fo[e].ovf;
        ma_q <= ev_m_o[e];
        fa_q <= ev_c_o[e];
        cb_q <= ca_q;
        tb_q <= t_d;
        ob_q <= oa_q | (|tf_d);
        mb_q <= ma_q;
        fb_q <= fa_q;
      end
    end

    assign ev_fi[e+1]    = {vb_q, ob_q};
    assign ev_p_i[e+1]   = $signed(tb_q[0]);
    assign ev_x_i[e+1]   = $signed(tb_q[1]);
    assign ev_y_i[e+1]   = $signed(tb_q[2]);
    assign ev_m_i[e+1]   = mb_q;
    assign ev_c_i[e+1]   = fb_q;
    assign ev_ctx_i[e+1] = cb_q;
  end

  // Final combination: y + floor((k1 + 2*k2 + 2*k3 + k4) * dt/6).
  // F1 adds k4, F2 forms two partial products with the halves of dt/6,
  // F3 joins them and drops 32 fraction bits, F4 adds the state.
  logic signed [W-1:0] k4_w [3];
  logic                f1_v_q, f2_v_q, f3_v_q, f4_v_q;
  logic                f1_o_q, f2_o_q, f3_o_q;
  ctx_t                f1_c_q;
  logic [2:0][W-1:0]   f2_y_q, f3_y_q;
  logic signed [LW-1:0] f2_lo_q [3];
  logic signed [HW-1:0] f2_hi_q [3];
  logic [W-1:0]        f3_m_q [3];
  logic [W:0]          f3_m_d [3];
  logic [W:0]          f4_r_d [3];
  res_t                f4_q;

  assign k4_w[0] = ev_dp[3];
  assign k4_w[1] = ev_dx[3];
  assign k4_w[2] = ev_dy[3];

  always_comb begin
    logic signed [WIDE-1:0] full;
    for (int i = 0; i < 3; i++) begin
      full      = (WIDE'(f2_hi_q[i]) <<< DT_BITS) + WIDE'(f2_lo_q[i]);
      f3_m_d[i] = sat_w(full >>> (2 * DT_BITS));
      f4_r_d[i] = sat_w(WIDE'($signed(f3_y_q[i])) + WIDE'($signed(f3_m_q[i])));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
      f3_v_q <= 1'b0;
      f4_v_q <= 1'b0;
    end else if (en) begin
      f1_v_q <= ev_fo[3].valid;
      f2_v_q <= f1_v_q;
      f3_v_q <= f2_v_q;
      f4_v_q <= f3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_c_q.y <= ev_ctx_o[3].y;
      for (int i = 0; i < 3; i++) begin
        f1_c_q.s[i] <= $signed(ev_ctx_o[3].s[i]) + KW'(k4_w[i]);
        f2_lo_q[i]  <= $signed(f1_c_q.s[i]) * $signed({1'b0, dt6_q[DT_BITS-1:0]});
        f2_hi_q[i]  <= $signed(f1_c_q.s[i]) * $signed({1'b0, dt6_q[DT6_W-1:DT_BITS]});
        f3_m_q[i]   <= f3_m_d[i][W-1:0];
      end
      f1_o_q    <= ev_fo[3].ovf;
      f2_o_q    <= f1_o_q;
      f2_y_q    <= f1_c_q.y;
      f3_o_q    <= f2_o_q | f3_m_d[0][W] | f3_m_d[1][W] | f3_m_d[2][W];
      f3_y_q    <= f2_y_q;
      f4_q.pot  <= f4_r_d[0][W-1:0];
      f4_q.vx   <= f4_r_d[1][W-1:0];
      f4_q.vy   <= f4_r_d[2][W-1:0];
      f4_q.ovf  <= f3_o_q | f4_r_d[0][W] | f4_r_d[1][W] | f4_r_d[2][W];
    end
  end

  // Output register with a one-entry skid register behind it.
  res_t out_q, skid_q;
  logic out_free;

  assign out_free = !out_v_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= f4_v_q;
      end
    end else if (en && f4_v_q) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_v_q ? skid_q : f4_q;
    end else if (en) begin
      skid_q <= f4_q;
    end
  end

  assign result_o.valid          = out_v_q;
  assign result_o.potential_out  = $signed(out_q.pot);
  assign result_o.velocity_x_out = $signed(out_q.vx);
  assign result_o.velocity_y_out = $signed(out_q.vy);
  assign result_o.overflow_flag  = out_q.ovf;

  // The skid register only ever holds a result behind a full output register.
  `RK_ASSERT_IMPL(a_skid_behind_out, clk_i, rst_ni, skid_v_q, out_v_q,
                  "skid register occupied while output register is empty")
  // The skid register fills only when the output was stalled.
  `RK_ASSERT_IMPL(a_skid_fill_on_stall, clk_i, rst_ni, $rose(skid_v_q),
                  $past(out_v_q && !result_o.ready),
                  "skid register filled without an output stall")
  // dt/6 is registered from the time step and matches it once the time step holds steady.
  `RK_ASSERT_IMPL(a_dt6_tracks, clk_i, rst_ni, $stable(time_step_q),
                  (34'(dt6_q) * 34'd6 <= 34'({time_step_q, {DT_BITS{1'b0}}})) &&
                  (34'({time_step_q, {DT_BITS{1'b0}}}) < 34'(dt6_q) * 34'd6 + 34'd6),
                  "dt/6 does not match the time step register")

endmodule

/* rtl/core/rk4dc_deriv.sv */
// ----------------------------------------------------------------------------
// rk4dc_deriv
// Pipelined derivative of one cell state: -(vx+vy) and -p/m - c*v for both
// velocities, with a one-bit-per-stage restoring divider for p/m.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rk4dc_deriv #(
  parameter int unsigned FRACTION_BITS = 16,
  parameter int unsigned VALUE_WIDTH   = 32,
  parameter int unsigned CTX_W         = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  rk4dc_pkg::stage_flags_t       flags_i,
  input  logic signed [VALUE_WIDTH-1:0] pot_i,
  input  logic signed [VALUE_WIDTH-1:0] vx_i,
  input  logic signed [VALUE_WIDTH-1:0] vy_i,
  input  logic        [VALUE_WIDTH-2:0] mass_i,
  input  logic        [VALUE_WIDTH-2:0] fric_i,
  input  logic        [CTX_W-1:0]       ctx_i,
  output rk4dc_pkg::stage_flags_t       flags_o,
  output logic signed [VALUE_WIDTH-1:0] dpot_o,
  output logic signed [VALUE_WIDTH-1:0] dvx_o,
  output logic signed [VALUE_WIDTH-1:0] dvy_o,
  output logic        [VALUE_WIDTH-2:0] mass_o,
  output logic        [VALUE_WIDTH-2:0] fric_o,
  output logic        [CTX_W-1:0]       ctx_o
);
  import rk4dc_pkg::*;

  localparam int unsigned W    = VALUE_WIDTH;
  localparam int unsigned F    = FRACTION_BITS;
  localparam int unsigned WIDE = 2 * W + 4;
  localparam int unsigned NDIV = W - 1;
  localparam int unsigned CW   = 2 * W - F;
  localparam logic signed [WIDE-1:0] VMAX_X = {{(W + 5){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [WIDE-1:0] VMIN_X = {{(W + 5){1'b1}}, {(W - 1){1'b0}}};
  localparam logic [W-1:0] VMAX_W = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0] VMIN_W = {1'b1, {(W - 1){1'b0}}};

  typedef struct packed {
    logic [W-2:0]     m;
    logic [W-2:0]     c;
    logic [CTX_W-1:0] ctx;
    logic [W-1:0]     d0;
    logic [W-1:0]     px;
    logic [W-1:0]     py;
    logic             neg;
    logic             pzero;
    logic             special;
    logic             ovf;
    logic [W-2:0]     r;
    logic [W-2:0]     q;
    logic [W-2:0]     nlow;
  } dv_t;

  // Clamp to the signed W-bit range; bit W reports that the clamp hit.
  function automatic logic [W:0] sat_w(input logic signed [WIDE-1:0] x);
    logic [W:0] r;
    if (x > VMAX_X) begin
      r = {1'b1, VMAX_W};
    end else if (x < VMIN_X) begin
      r = {1'b1, VMIN_W};
    end else begin
      r = {1'b0, x[W-1:0]};
    end
    return r;
  endfunction

  // Stage A: magnitude of p, friction products and the potential derivative.
  logic                  a_v_q;
  logic [W-1:0]          a_mp_q;
  logic                  a_neg_q, a_pz_q, a_mz_q, a_ovf_q;
  logic signed [2*W-1:0] a_prx_q, a_pry_q;
  logic [W-1:0]          a_d0_q;
  logic [W-2:0]          a_m_q, a_c_q;
  logic [CTX_W-1:0]      a_ctx_q;
  logic [W:0]            a_d0_d;

  assign a_d0_d = sat_w(-(WIDE'(vx_i) + WIDE'(vy_i)));

  // Stage B and the divider stages.
  dv_t         dv_d [NDIV+1];
  dv_t         dv_q [NDIV+1];
  logic [NDIV:0] dv_v_q;

  always_comb begin
    logic [W+F-1:0] nf;
    logic [W:0]     sx;
    logic [W:0]     sy;
    logic [W-1:0]   r2;
    logic           ge;
    nf = {a_mp_q, {F{1'b0}}};
    sx = sat_w(WIDE'(a_prx_q >>> F));
    sy = sat_w(WIDE'(a_pry_q >>> F));
    dv_d[0].m     = a_m_q;
    dv_d[0].c     = a_c_q;
    dv_d[0].ctx   = a_ctx_q;
    dv_d[0].d0    = a_d0_q;
    dv_d[0].px    = sx[W-1:0];
    dv_d[0].py    = sy[W-1:0];
    dv_d[0].neg   = a_neg_q;
    dv_d[0].pzero = a_pz_q;
    // The quotient cannot fit when |p| >= m * 2^(W-1-F), or when m is zero.
    dv_d[0].special = a_mz_q || (CW'(a_mp_q) >= CW'({a_m_q, {(W - 1 - F){1'b0}}}));
    dv_d[0].ovf   = a_ovf_q | sx[W] | sy[W];
    dv_d[0].r     = (W - 1)'(a_mp_q >> (W - 1 - F));
    dv_d[0].q     = '0;
    dv_d[0].nlow  = nf[W-2:0];
    for (int j = 0; j < NDIV; j++) begin
      r2 = {dv_q[j].r, dv_q[j].nlow[W-2]};
      ge = (r2 >= {1'b0, dv_q[j].m});
      dv_d[j+1]      = dv_q[j];
      dv_d[j+1].r    = ge ? (W - 1)'(r2 - {1'b0, dv_q[j].m}) : (W - 1)'(r2);
      dv_d[j+1].q    = {dv_q[j].q[W-3:0], ge};
      dv_d[j+1].nlow = {dv_q[j].nlow[W-3:0], 1'b0};
    end
  end

  // Stage C: signed quotient and the two velocity derivatives.
  dv_t                 cq;
  logic signed [W-1:0] acc;
  logic                accf;
  logic [W:0]          s1, s2;

  assign cq = dv_q[NDIV];

  always_comb begin
    accf = 1'b0;
    if (cq.pzero) begin
      acc = '0;
    end else if (cq.special) begin
      acc  = cq.neg ? VMIN_W : VMAX_W;
      accf = 1'b1;
    end else if (cq.neg) begin
      acc = -$signed({1'b0, cq.q});
    end else begin
      acc = $signed({1'b0, cq.q});
    end
    s1 = sat_w(WIDE'(acc) - WIDE'($signed(cq.px)));
    s2 = sat_w(WIDE'(acc) - WIDE'($signed(cq.py)));
  end

  logic             c_v_q;
  logic             c_ovf_q;
  logic [W-1:0]     c_d0_q, c_d1_q, c_d2_q;
  logic [W-2:0]     c_m_q, c_c_q;
  logic [CTX_W-1:0] c_ctx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q  <= 1'b0;
      dv_v_q <= '0;
      c_v_q  <= 1'b0;
    end else if (en_i) begin
      a_v_q  <= flags_i.valid;
      dv_v_q <= {dv_v_q[NDIV-1:0], a_v_q};
      c_v_q  <= dv_v_q[NDIV];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_mp_q  <= pot_i[W-1] ? W'(-pot_i) : W'(pot_i);
      a_neg_q <= !pot_i[W-1] && (pot_i != '0);
      a_pz_q  <= (pot_i == '0);
      a_mz_q  <= (mass_i == '0);
      a_prx_q <= $signed({1'b0, fric_i}) * vx_i;
      a_pry_q <= $signed({1'b0, fric_i}) * vy_i;
      a_d0_q  <= a_d0_d[W-1:0];
      a_ovf_q <= flags_i.ovf | a_d0_d[W];
      a_m_q   <= mass_i;
      a_c_q   <= fric_i;
      a_ctx_q <= ctx_i;
      for (int j = 0; j <= NDIV; j++) begin
        dv_q[j] <= dv_d[j];
      end
      c_ovf_q <= cq.ovf | accf | s1[W] | s2[W];
      c_d0_q  <= cq.d0;
      c_d1_q  <= s1[W-1:0];
      c_d2_q  <= s2[W-1:0];
      c_m_q   <= cq.m;
      c_c_q   <= cq.c;
      c_ctx_q <= cq.ctx;
    end
  end

  assign flags_o = '{valid: c_v_q, ovf: c_ovf_q};
  assign dpot_o  = $signed(c_d0_q);
  assign dvx_o   = $signed(c_d1_q);
  assign dvy_o   = $signed(c_d2_q);
  assign mass_o  = c_m_q;
  assign fric_o  = c_c_q;
  assign ctx_o   = c_ctx_q;

endmodule

/* sim/rk4_damped_cell_integrator_test.sv */
// ----------------------------------------------------------------------------
// rk4_damped_cell_integrator_test
// Self-checking bench for one fourth-order Runge-Kutta cell step.
// ----------------------------------------------------------------------------
// A queue of cells feeds a bursty driver. Every accepted cell is predicted
// in fixed point at the time step in force, and a monitor compares each
// result transaction field by field with the oldest prediction. The time
// step is rewritten between phases while the block is empty, and the
// receiver stalls on its own pattern, once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rk4_damped_cell_integrator_test;

  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;
  localparam int LATENCY = 4 * 32 + 20;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic signed [31:0] p;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [30:0] m;
    logic [30:0] c;
  } cell_t;

  localparam int CELL_W = $bits(cell_t);

  typedef struct packed {
    logic signed [31:0] p;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic ovf;
  } cell_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rk4dc_in_if #(.VALUE_WIDTH(32)) din ();
  rk4dc_out_if #(.VALUE_WIDTH(32)) dout ();
  rk4dc_cfg_if cfg ();

  rk4_damped_cell_integrator dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_i(cfg),
    .data_in_i(din),
    .result_o(dout)
  );

  always #2 clk_i = ~clk_i;

  cell_t pending_cells[$];
  cell_result_t expected_steps[$];
  logic [15:0] step_size = 16'd655;
  int cells_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int overflow_results = 0;
  int idle_cycles = 0;

  // ---------------------------------------------------------------- predictor
  function automatic longint clamp32(longint x, inout bit ovf);
    if (x > VMAX) begin
      ovf = 1'b1;
      return VMAX;
    end
    if (x < VMIN) begin
      ovf = 1'b1;
      return VMIN;
    end
    return x;
  endfunction

  function automatic longint signed_from_mag(bit neg, logic [127:0] mag, inout bit ovf);
    if (neg) begin
      if (mag > 128'd2147483648) begin
        ovf = 1'b1;
        return VMIN;
      end
      return -longint'(mag[63:0]);
    end
    if (mag > 128'd2147483647) begin
      ovf = 1'b1;
      return VMAX;
    end
    return longint'(mag[63:0]);
  endfunction

  // Product shifted right, rounded toward minus infinity, then clamped.
  function automatic longint mul_floor(longint a, longint b, int sh, inout bit ovf);
    bit neg;
    logic [127:0] ma, mb, prod, q, rem;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? 128'(-a) : 128'(a);
    mb = (b < 0) ? 128'(-b) : 128'(b);
    prod = ma * mb;
    q = prod >> sh;
    rem = prod & ((128'd1 << sh) - 1);
    if (neg && rem != 0) q = q + 1;
    return signed_from_mag(neg, q, ovf);
  endfunction

  // -p/m truncated toward zero in Q16.16.
  function automatic longint neg_quotient(longint p, longint m, inout bit ovf);
    bit neg;
    longint mp;
    neg = p > 0;
    mp = (p < 0) ? -p : p;
    if (mp == 0) return 0;
    if (mp / m > 32767) return signed_from_mag(neg, {128{1'b1}}, ovf);
    return signed_from_mag(neg, 128'((mp << 16) / m), ovf);
  endfunction

  function automatic void slope(input longint s[3], input longint m, input longint c,
                                output longint d[3], inout bit ovf);
    longint acc;
    acc = neg_quotient(s[0], m, ovf);
    d[0] = clamp32(-(s[1] + s[2]), ovf);
    d[1] = clamp32(acc - mul_floor(c, s[1], 16, ovf), ovf);
    d[2] = clamp32(acc - mul_floor(c, s[2], 16, ovf), ovf);
  endfunction

  function automatic cell_result_t rk4_predict(cell_t item, logic [15:0] dt);
    longint y[3], k1[3], k2[3], k3[3], k4[3], t[3], r[3];
    longint m, c, dt6, sum;
    bit ovf;
    cell_result_t res;
    ovf = 1'b0;
    y[0] = longint'(item.p);
    y[1] = longint'(item.vx);
    y[2] = longint'(item.vy);
    m = longint'({33'd0, item.m});
    c = longint'({33'd0, item.c});
    dt6 = (longint'(dt) << 16) / 6;
    slope(y, m, c, k1, ovf);
    for (int i = 0; i < 3; i++) t[i] = clamp32(y[i] + mul_floor(k1[i], dt, 17, ovf), ovf);
    slope(t, m, c, k2, ovf);
    for (int i = 0; i < 3; i++) t[i] = clamp32(y[i] + mul_floor(k2[i], dt, 17, ovf), ovf);
    slope(t, m, c, k3, ovf);
    for (int i = 0; i < 3; i++) t[i] = clamp32(y[i] + mul_floor(k3[i], dt, 16, ovf), ovf);
    slope(t, m, c, k4, ovf);
    for (int i = 0; i < 3; i++) begin
      sum = k1[i] + 2 * k2[i] + 2 * k3[i] + k4[i];
      r[i] = clamp32(y[i] + mul_floor(sum, dt6, 32, ovf), ovf);
    end
    res.p = r[0][31:0];
    res.vx = r[1][31:0];
    res.vy = r[2][31:0];
    res.ovf = ovf;
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic cell_t make_cell(longint p, longint vx, longint vy, longint m,
                                      longint c);
    cell_t item;
    item.p = p[31:0];
    item.vx = vx[31:0];
    item.vy = vy[31:0];
    item.m = m[30:0];
    item.c = c[30:0];
    return item;
  endfunction

  function automatic longint spread(int bits);
    longint r;
    r = longint'(1) << bits;
    return longint'({$urandom, $urandom}) % r;
  endfunction

  // Mostly physically sensible cells, with some fully random ones and extremes.
  function automatic cell_t random_cell();
    int kind;
    int mag;
    cell_t item;
    kind = $urandom_range(0, 9);
    mag = $urandom_range(8, 26);
    if (kind < 2) begin
      item = CELL_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
      if (item.m == 0) item.m = 31'd1;
    end else if (kind < 8) begin
      item = make_cell(spread(mag), spread(mag), spread(mag),
                       $urandom_range(1, 1 << $urandom_range(4, 22)),
                       $urandom_range(0, 1 << $urandom_range(0, 20)));
    end else begin
      item = make_cell($urandom_range(0, 1) ? VMAX : VMIN,
                       $urandom_range(0, 1) ? VMAX : spread(mag),
                       $urandom_range(0, 1) ? VMIN : spread(mag),
                       $urandom_range(0, 1) ? 1 : 64'h7FFF_FFFF,
                       $urandom_range(0, 1) ? 0 : 64'h7FFF_FFFF);
    end
    return item;
  endfunction

  // ---------------------------------------------------------------- driver
  // Bursts of random length separated by random gaps, sometimes none at all.
  cell_t cell_on_bus;
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (din.valid && din.ready) begin
        expected_steps.push_back(rk4_predict(cell_on_bus, step_size));
        cells_sent++;
      end
      if (!din.valid || din.ready) begin
        if (gap_left > 0) begin
          din.valid <= 1'b0;
          gap_left--;
        end else if (pending_cells.size() > 0) begin
          cell_on_bus = pending_cells.pop_front();
          din.potential_in <= cell_on_bus.p;
          din.velocity_x_in <= cell_on_bus.vx;
          din.velocity_y_in <= cell_on_bus.vy;
          din.cell_mass <= cell_on_bus.m;
          din.cell_friction <= cell_on_bus.c;
          din.valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          din.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  // The receiver switches among random stall patterns; once, after 360 cells,
  // it holds ready low while the sender still has more cells queued than the
  // pipeline holds, so that it fills and stalls.
  int rx_cycle = 0;
  int rx_mode = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
      if (!hold_done && cells_sent >= 360) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        dout.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: dout.ready <= 1'b1;
          1: dout.ready <= ($urandom_range(0, 9) >= 3);
          2: dout.ready <= ($urandom_range(0, 9) >= 7);
          default: dout.ready <= ((rx_cycle / 8) % 2 == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk_i) begin
    cell_result_t want;
    if (rst_ni && dout.valid && dout.ready) begin
      results_seen++;
      if (dout.overflow_flag) overflow_results++;
      if (expected_steps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction at %0t ns", $realtime);
      end else begin
        want = expected_steps.pop_front();
        if (dout.potential_out !== want.p || dout.velocity_x_out !== want.vx ||
            dout.velocity_y_out !== want.vy || dout.overflow_flag !== want.ovf) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch in result %0d: expected p=%0d vx=%0d vy=%0d ovf=%0b",
                     results_seen, want.p, want.vx, want.vy, want.ovf);
            $display("  actual p=%0d vx=%0d vy=%0d ovf=%0b", dout.potential_out,
                     dout.velocity_x_out, dout.velocity_y_out, dout.overflow_flag);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((din.valid && din.ready) || (dout.valid && dout.ready) || (cfg.valid && cfg.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding", expected_steps.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  task automatic wait_empty();
    do @(posedge clk_i);
    while (pending_cells.size() != 0 || din.valid || expected_steps.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_step(logic [15:0] value);
    cfg.valid <= 1'b1;
    cfg.time_step <= value;
    do @(posedge clk_i);
    while (!(cfg.valid && cfg.ready));
    step_size = value;
    cfg.valid <= 1'b0;
  endtask

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++) pending_cells.push_back(random_cell());
  endtask

  initial begin
    din.valid = 1'b0;
    din.potential_in = '0;
    din.velocity_x_in = '0;
    din.velocity_y_in = '0;
    din.cell_mass = 31'd1;
    din.cell_friction = '0;
    dout.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.time_step = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed cells at the reset time step: extremes of every field, zero
    // potential, quotient saturation on a tiny mass, and derivative overflow.
    pending_cells.push_back(make_cell(0, 0, 0, 1, 0));
    pending_cells.push_back(make_cell(0, 0, 0, 64'h7FFF_FFFF, 64'h7FFF_FFFF));
    pending_cells.push_back(make_cell(VMAX, 0, 0, 1, 0));
    pending_cells.push_back(make_cell(VMIN, 0, 0, 1, 0));
    pending_cells.push_back(make_cell(VMAX, VMAX, VMAX, 64'h7FFF_FFFF, 0));
    pending_cells.push_back(make_cell(VMIN, VMIN, VMIN, 64'h7FFF_FFFF, 0));
    pending_cells.push_back(make_cell(0, VMAX, VMAX, 65536, 65536));
    pending_cells.push_back(make_cell(0, VMIN, VMIN, 65536, 65536));
    pending_cells.push_back(make_cell(65536, 0, 0, 65536, 0));
    pending_cells.push_back(make_cell(-65536, 0, 0, 65536, 0));
    pending_cells.push_back(make_cell(0, VMAX, VMIN, 65536, 64'h7FFF_FFFF));
    pending_cells.push_back(make_cell(0, VMIN, VMAX, 65536, 64'h7FFF_FFFF));
    pending_cells.push_back(make_cell(32767 * 65536, 0, 0, 65536, 0));
    pending_cells.push_back(make_cell(-1, 1, -1, 1, 1));
    pending_cells.push_back(make_cell(1, -1, 1, 64'h7FFF_FFFF, 1));
    pending_cells.push_back(make_cell(VMAX, VMIN, VMAX, 2, 64'h4000_0000));
    pending_cells.push_back(make_cell(-123456, 654321, -98765, 98304, 3277));
    pending_cells.push_back(make_cell(64'hFFFF_FFFF_AAAA_AAAA, 64'h5555_5555,
                                      64'hFFFF_FFFF_AAAA_AAAA, 64'h2AAA_AAAA,
                                      64'h5555_5555));
    queue_random(180);
    wait_empty();

    // The extremes of the time step, then a random one, then the smallest nonzero one.
    write_step(16'd0);
    queue_random(150);
    wait_empty();
    write_step(16'hFFFF);
    queue_random(200);
    wait_empty();
    write_step(16'($urandom_range(1, 65534)));
    queue_random(150);
    wait_empty();
    write_step(16'd1);
    queue_random(150);
    wait_empty();

    repeat (LATENCY + 50) @(posedge clk_i);
    $display("Checked %0d of %0d cells over five time steps, %0d with overflow.",
             results_seen, cells_sent, overflow_results);
    $display("Mismatches: %0d, results never delivered: %0d", mismatches,
             expected_steps.size());
    if (mismatches == 0 && expected_steps.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
